// ===== design/ppsched_pkg.sv =====
// Package for the pass-priority process scheduler: types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppsched_pkg;
	localparam int ENTRIES = 64;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [7:0] START_PRIORITY = 8'd5;

	typedef enum logic [2:0] {
		ST_FREE  = 3'd0,
		ST_NEW   = 3'd1,
		ST_SLEEP = 3'd2,
		ST_READY = 3'd3,
		ST_RUN   = 3'd4,
		ST_DONE  = 3'd5
	} ent_state_t;

	typedef enum logic [3:0] {
		OP_ALLOC  = 4'd0,
		OP_READY  = 4'd1,
		OP_PICK   = 4'd2,
		OP_YIELD  = 4'd3,
		OP_SLEEP  = 4'd4,
		OP_WAKE   = 4'd5,
		OP_KILL   = 4'd6,
		OP_SETPRI = 4'd7,
		OP_EXIT   = 4'd8,
		OP_REAP   = 4'd9,
		OP_TICK   = 4'd10
	} opcode_t;

	localparam logic [1:0] MODE_PASS = 2'd2;

	typedef enum logic [2:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_SCAN,
		SQ_FETCH,
		SQ_ACT,
		SQ_OUT
	} seq_state_t;

	typedef struct packed {
		ent_state_t  st;
		logic [15:0] pid;
		logic [7:0]  pri;
		logic [31:0] pass;
		logic [31:0] chan;
		logic        kil;
		logic [31:0] rtk;
		logic [31:0] stk;
	} entry_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [5:0]  slot_index;
		logic [15:0] target_pid;
		logic [7:0]  priority_value;
		logic [31:0] channel_value;
	} in_beat_t;

	typedef struct packed {
		logic        ok;
		logic [5:0]  result_slot;
		logic [15:0] result_pid;
		logic [31:0] ready_count;
		logic [31:0] sleep_count;
		logic        was_killed;
	} out_beat_t;
endpackage
`default_nettype wire

// ===== design/pass_priority_process_scheduler_unit.sv =====
// Pass-priority process scheduler, top level.
// Input beats are accepted only while idle; the result beat is then built by a sweep over
//   the table, one target read and one update, and is offered from a register.
// A new beat is taken only after the previous result beat leaves; in_ready returns the cycle
//   after the result beat leaves, so output stalls delay the next beat directly.
// Reset: a clearing pass over all ENTRIES slots marks every slot unused, in_ready low
//   meanwhile; next pid 1, no current entry, mode 0. Depends on ppsched_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pass_priority_process_scheduler_unit
	import ppsched_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [1:0] cfg_wdata,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_beat_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_beat_t      out_data
);
	entry_t           tbl_q [ENTRIES];
	entry_t           rd_s1;
	logic [IDX_W-1:0] ra_s1;
	logic             rv_s1;

	logic [1:0]       mode_q;
	logic [15:0]      next_pid_q;
	logic [IDX_W-1:0] cur_q, rot_q;
	logic             cur_v_q;
	seq_state_t       sq_q, sq_d;
	in_beat_t         op_q;
	logic [CNT_W-1:0] k_q;
	logic             fnd_q, any_q;
	logic [IDX_W-1:0] hit_q;
	logic [31:0]      least_q;
	out_beat_t        res_q;

	logic [IDX_W-1:0] si, tgt, rd_addr, wr_addr;
	logic             scan_end, clr_end, wr_en;
	entry_t           ent_d;
	out_beat_t        res_d;
	logic [32:0]      pass_sum;

	// sweep address
	always_comb begin
		if (op_q.opcode == OP_PICK && mode_q != MODE_PASS)
			si = IDX_W'((CNT_W'(rot_q) + k_q) % CNT_W'(ENTRIES));
		else
			si = k_q[IDX_W-1:0];
		scan_end = (k_q == CNT_W'(ENTRIES));
		clr_end = (k_q == CNT_W'(ENTRIES - 1));
	end

	always_comb begin
		unique case (op_q.opcode)
			OP_READY, OP_REAP:           tgt = op_q.slot_index[IDX_W-1:0];
			OP_YIELD, OP_SLEEP, OP_EXIT: tgt = cur_q;
			default:                     tgt = hit_q;
		endcase
		rd_addr = (sq_q == SQ_SCAN) ? si : tgt;
	end

	assign pass_sum = {1'b0, rd_s1.pass} + 33'(rd_s1.pri);

	always_comb begin
		unique case (sq_q)
			SQ_CLEAR: sq_d = clr_end ? SQ_IDLE : SQ_CLEAR;
			SQ_IDLE:  sq_d = in_valid ? SQ_SCAN : SQ_IDLE;
			SQ_SCAN:  sq_d = scan_end ? SQ_FETCH : SQ_SCAN;
			SQ_FETCH: sq_d = SQ_ACT;
			SQ_ACT:   sq_d = SQ_OUT;
			SQ_OUT:   sq_d = out_ready ? SQ_IDLE : SQ_OUT;
			default:  sq_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (sq_q == SQ_IDLE);
		out_valid = (sq_q == SQ_OUT);
		out_data = res_q;
	end

	// table write port and result of the update step
	always_comb begin
		ent_d = rd_s1;
		wr_en = 1'b0;
		wr_addr = ra_s1;
		res_d = '0;
		unique case (sq_q)
			SQ_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = k_q[IDX_W-1:0];
				ent_d = '0;
			end
			SQ_SCAN: if (rv_s1) begin
				priority if (op_q.opcode == OP_WAKE && rd_s1.st == ST_SLEEP
						&& rd_s1.chan == op_q.channel_value) begin
					wr_en = 1'b1;
					ent_d.st = ST_READY;
				end else if (op_q.opcode == OP_TICK && rd_s1.st == ST_READY
						&& rd_s1.rtk != '1) begin
					wr_en = 1'b1;
					ent_d.rtk = rd_s1.rtk + 32'd1;
				end else if (op_q.opcode == OP_TICK && rd_s1.st == ST_SLEEP
						&& rd_s1.stk != '1) begin
					wr_en = 1'b1;
					ent_d.stk = rd_s1.stk + 32'd1;
				end
			end
			SQ_ACT: begin
				wr_addr = tgt;
				unique case (op_q.opcode)
					OP_ALLOC: if (fnd_q) begin
						wr_en = 1'b1;
						ent_d = '0;
						ent_d.st = ST_NEW;
						ent_d.pid = next_pid_q;
						ent_d.pri = START_PRIORITY;
						ent_d.pass = any_q ? least_q : 32'd0;
						res_d.ok = 1'b1;
						res_d.result_slot = 6'(hit_q);
						res_d.result_pid = next_pid_q;
					end
					OP_READY: if (CNT_W'(op_q.slot_index) < CNT_W'(ENTRIES)
							&& rd_s1.st == ST_NEW) begin
						wr_en = 1'b1;
						ent_d.st = ST_READY;
						res_d.ok = 1'b1;
					end
					// a current entry is always running: only yield, sleep and exit
					// move it, and they clear the current flag
					OP_PICK: if (!cur_v_q && fnd_q) begin
						wr_en = 1'b1;
						ent_d.st = ST_RUN;
						res_d.ok = 1'b1;
						res_d.result_slot = 6'(hit_q);
						res_d.result_pid = rd_s1.pid;
					end
					OP_YIELD, OP_SLEEP, OP_EXIT: if (cur_v_q) begin
						wr_en = 1'b1;
						res_d.ok = 1'b1;
						if (op_q.opcode == OP_YIELD) begin
							ent_d.st = ST_READY;
							if (mode_q == MODE_PASS)
								ent_d.pass = pass_sum[32] ? '1 : pass_sum[31:0];
						end else if (op_q.opcode == OP_SLEEP) begin
							ent_d.chan = op_q.channel_value;
							ent_d.st = ST_SLEEP;
						end else begin
							ent_d.st = ST_DONE;
						end
					end
					OP_WAKE: res_d.ok = fnd_q;
					OP_KILL: if (fnd_q) begin
						wr_en = 1'b1;
						ent_d.kil = 1'b1;
						if (rd_s1.st == ST_SLEEP) ent_d.st = ST_READY;
						res_d.ok = 1'b1;
					end
					OP_SETPRI: if (fnd_q) begin
						wr_en = 1'b1;
						ent_d.pri = op_q.priority_value;
						res_d.ok = 1'b1;
					end
					OP_REAP: if (CNT_W'(op_q.slot_index) < CNT_W'(ENTRIES)
							&& rd_s1.st == ST_DONE) begin
						wr_en = 1'b1;
						res_d.ok = 1'b1;
						res_d.result_slot = op_q.slot_index;
						res_d.result_pid = rd_s1.pid;
						res_d.ready_count = rd_s1.rtk;
						res_d.sleep_count = rd_s1.stk;
						res_d.was_killed = rd_s1.kil;
						ent_d.st = ST_FREE;
						ent_d.pid = '0;
						ent_d.kil = 1'b0;
					end
					OP_TICK: res_d.ok = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) tbl_q[wr_addr] <= ent_d;
		rd_s1 <= tbl_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= SQ_CLEAR;
			mode_q <= 2'd0;
			next_pid_q <= 16'd1;
			cur_q <= '0;
			cur_v_q <= 1'b0;
			rot_q <= '0;
			k_q <= '0;
			fnd_q <= 1'b0;
			any_q <= 1'b0;
			hit_q <= '0;
			least_q <= '0;
			res_q <= '0;
			ra_s1 <= '0;
			rv_s1 <= 1'b0;
		end else begin
			sq_q <= sq_d;
			if (cfg_we) mode_q <= cfg_wdata;
			unique case (sq_q)
				SQ_CLEAR: k_q <= k_q + 1'b1;
				SQ_IDLE: begin
					k_q <= '0;
					fnd_q <= 1'b0;
					any_q <= 1'b0;
					rv_s1 <= 1'b0;
				end
				SQ_SCAN: begin
					k_q <= k_q + 1'b1;
					rv_s1 <= !scan_end;
					ra_s1 <= si;
					if (rv_s1) begin
						unique case (op_q.opcode)
							OP_ALLOC: begin
								if (rd_s1.st == ST_FREE && !fnd_q) begin
									fnd_q <= 1'b1;
									hit_q <= ra_s1;
								end
								if (rd_s1.st != ST_FREE && rd_s1.st != ST_NEW) begin
									if (!any_q || rd_s1.pass < least_q) least_q <= rd_s1.pass;
									any_q <= 1'b1;
								end
							end
							OP_PICK: begin
								if (rd_s1.st == ST_READY) begin
									if (mode_q == MODE_PASS) begin
										if (!fnd_q || rd_s1.pass < least_q) begin
											fnd_q <= 1'b1;
											hit_q <= ra_s1;
											least_q <= rd_s1.pass;
										end
									end else if (!fnd_q) begin
										fnd_q <= 1'b1;
										hit_q <= ra_s1;
									end
								end
							end
							OP_WAKE: begin
								if (rd_s1.st == ST_SLEEP && rd_s1.chan == op_q.channel_value)
									fnd_q <= 1'b1;
							end
							OP_KILL, OP_SETPRI: begin
								if (!fnd_q && rd_s1.st != ST_FREE
										&& rd_s1.pid == op_q.target_pid) begin
									fnd_q <= 1'b1;
									hit_q <= ra_s1;
								end
							end
							default: ;
						endcase
					end
				end
				SQ_ACT: begin
					res_q <= res_d;
					if (res_d.ok) begin
						unique case (op_q.opcode)
							OP_ALLOC:
								next_pid_q <= (next_pid_q == 16'hFFFF) ? 16'd1
									: next_pid_q + 1'b1;
							OP_PICK: begin
								cur_q <= hit_q;
								cur_v_q <= 1'b1;
								if (mode_q != MODE_PASS)
									rot_q <= IDX_W'((CNT_W'(hit_q) + 1'b1) % CNT_W'(ENTRIES));
							end
							OP_YIELD, OP_SLEEP, OP_EXIT: cur_v_q <= 1'b0;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) op_q <= in_data;
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	a_act_len: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_q == SQ_ACT) |-> $past(sq_q) == SQ_FETCH) else $error("act without fetch");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.ok) |-> out_data.result_pid == 16'd0)
		else $error("failed beat carries data");
	a_pid_nz: assert property (@(posedge clk) disable iff (!arst_n)
		next_pid_q != 16'd0) else $error("pid zero");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for pass_priority_process_scheduler_unit: directed table, then random op streams.
// Expected beats come from an in-bench process-table predictor. Depends on ppsched_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import ppsched_pkg::*;

	localparam int LAT = ENTRIES + 3;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic       chk;
		in_beat_t   req;
		out_beat_t  want;
	} dir_row_t;

	logic clk, arst_n, cfg_we, in_valid, out_ready;
	logic [1:0] cfg_wdata;
	in_beat_t in_data;
	logic in_ready, out_valid;
	out_beat_t out_data;

	pass_priority_process_scheduler_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor state
	ent_state_t  tbl_state [ENTRIES];
	logic [15:0] tbl_pid [ENTRIES];
	logic [7:0]  tbl_pri [ENTRIES];
	logic [31:0] tbl_pass [ENTRIES];
	logic [31:0] tbl_chan [ENTRIES];
	logic        tbl_kill [ENTRIES];
	logic [31:0] tbl_rdy [ENTRIES];
	logic [31:0] tbl_slp [ENTRIES];
	logic [15:0] pid_next;
	int          cur_slot;
	logic        cur_valid;
	int          rot_ptr;
	logic [1:0]  sched_mode;

	out_beat_t sched_results_q [$];
	logic      chk_q [$];
	out_beat_t dir_want_q [$];
	int errors, mism, idle_cycles;
	int p_send, p_stall;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = a + b;
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic int pid_slot(logic [15:0] p);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_state[i] != ST_FREE && tbl_pid[i] == p) return i;
		return -1;
	endfunction

	function automatic out_beat_t schedule_op(in_beat_t b);
		out_beat_t r;
		int i, pk;
		logic any;
		logic [31:0] least;
		logic running;
		r = '0;
		running = cur_valid && tbl_state[cur_slot] == ST_RUN;
		case (b.opcode)
			OP_ALLOC: begin
				pk = -1;
				for (i = 0; i < ENTRIES; i++)
					if (pk < 0 && tbl_state[i] == ST_FREE) pk = i;
				if (pk >= 0) begin
					any = 0;
					least = 0;
					for (i = 0; i < ENTRIES; i++)
						if (tbl_state[i] != ST_FREE && tbl_state[i] != ST_NEW) begin
							if (!any || tbl_pass[i] < least) least = tbl_pass[i];
							any = 1;
						end
					tbl_state[pk] = ST_NEW;
					tbl_pid[pk] = pid_next;
					tbl_pri[pk] = START_PRIORITY;
					tbl_pass[pk] = least;
					tbl_chan[pk] = 0;
					tbl_kill[pk] = 0;
					tbl_rdy[pk] = 0;
					tbl_slp[pk] = 0;
					r.ok = 1;
					r.result_slot = 6'(pk);
					r.result_pid = pid_next;
					pid_next = (pid_next == 16'hFFFF) ? 16'd1 : pid_next + 16'd1;
				end
			end
			OP_READY:
				if (tbl_state[b.slot_index] == ST_NEW) begin
					tbl_state[b.slot_index] = ST_READY;
					r.ok = 1;
				end
			OP_PICK:
				if (!running) begin
					pk = -1;
					if (sched_mode == MODE_PASS) begin
						for (i = 0; i < ENTRIES; i++)
							if (tbl_state[i] == ST_READY && (pk < 0 || tbl_pass[i] < tbl_pass[pk]))
								pk = i;
					end else begin
						for (i = 0; i < ENTRIES; i++)
							if (pk < 0 && tbl_state[(rot_ptr + i) % ENTRIES] == ST_READY)
								pk = (rot_ptr + i) % ENTRIES;
						if (pk >= 0) rot_ptr = (pk + 1) % ENTRIES;
					end
					if (pk >= 0) begin
						tbl_state[pk] = ST_RUN;
						cur_slot = pk;
						cur_valid = 1;
						r.ok = 1;
						r.result_slot = 6'(pk);
						r.result_pid = tbl_pid[pk];
					end
				end
			OP_YIELD, OP_SLEEP, OP_EXIT:
				if (running) begin
					if (b.opcode == OP_YIELD) begin
						tbl_state[cur_slot] = ST_READY;
						if (sched_mode == MODE_PASS)
							tbl_pass[cur_slot] = sat_inc(tbl_pass[cur_slot], 32'(tbl_pri[cur_slot]));
					end else if (b.opcode == OP_SLEEP) begin
						tbl_chan[cur_slot] = b.channel_value;
						tbl_state[cur_slot] = ST_SLEEP;
					end else tbl_state[cur_slot] = ST_DONE;
					cur_valid = 0;
					r.ok = 1;
				end
			OP_WAKE:
				for (i = 0; i < ENTRIES; i++)
					if (tbl_state[i] == ST_SLEEP && tbl_chan[i] == b.channel_value) begin
						tbl_state[i] = ST_READY;
						r.ok = 1;
					end
			OP_KILL: begin
				pk = pid_slot(b.target_pid);
				if (pk >= 0) begin
					tbl_kill[pk] = 1;
					if (tbl_state[pk] == ST_SLEEP) tbl_state[pk] = ST_READY;
					r.ok = 1;
				end
			end
			OP_SETPRI: begin
				pk = pid_slot(b.target_pid);
				if (pk >= 0) begin
					tbl_pri[pk] = b.priority_value;
					r.ok = 1;
				end
			end
			OP_REAP:
				if (tbl_state[b.slot_index] == ST_DONE) begin
					pk = b.slot_index;
					r.ok = 1;
					r.result_slot = 6'(pk);
					r.result_pid = tbl_pid[pk];
					r.ready_count = tbl_rdy[pk];
					r.sleep_count = tbl_slp[pk];
					r.was_killed = tbl_kill[pk];
					tbl_state[pk] = ST_FREE;
					tbl_pid[pk] = 0;
					tbl_kill[pk] = 0;
				end
			OP_TICK: begin
				for (i = 0; i < ENTRIES; i++)
					if (tbl_state[i] == ST_READY) tbl_rdy[i] = sat_inc(tbl_rdy[i], 32'd1);
					else if (tbl_state[i] == ST_SLEEP) tbl_slp[i] = sat_inc(tbl_slp[i], 32'd1);
				r.ok = 1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send(in_beat_t b);
		in_valid <= 1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		sched_results_q.push_back(schedule_op(b));
		if (p_send > 0 && $urandom_range(99) < p_send) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < p_send);
		end
	endtask

	// sends and, for checked rows, also queues a hand-typed expectation
	task automatic send_row(dir_row_t row);
		chk_q.push_back(row.chk);
		if (row.chk) dir_want_q.push_back(row.want);
		send(row.req);
	endtask

	task automatic drain_and_set_mode(logic [1:0] m);
		in_valid <= 0;
		while (sched_results_q.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 0;
		sched_mode = m;
	endtask

	function automatic in_beat_t mk(opcode_t op, int s, int p, int pr, logic [31:0] ch);
		in_beat_t b;
		b.opcode = op;
		b.slot_index = 6'(s);
		b.target_pid = 16'(p);
		b.priority_value = 8'(pr);
		b.channel_value = ch;
		return b;
	endfunction

	function automatic in_beat_t rand_beat();
		in_beat_t b;
		int r;
		b = '0;
		b.priority_value = 8'($urandom);
		b.slot_index = 6'($urandom_range(7));
		if ($urandom_range(9) == 0) b.slot_index = 6'($urandom);
		b.target_pid = pid_next - 16'($urandom_range(1, 10));
		if ($urandom_range(9) == 0) b.target_pid = 16'($urandom);
		b.channel_value = $urandom_range(3);
		if ($urandom_range(9) == 0) b.channel_value = $urandom;
		r = $urandom_range(99);
		if (r < 14) b.opcode = OP_ALLOC;
		else if (r < 26) b.opcode = OP_READY;
		else if (r < 42) b.opcode = OP_PICK;
		else if (r < 52) b.opcode = OP_YIELD;
		else if (r < 60) b.opcode = OP_SLEEP;
		else if (r < 67) b.opcode = OP_WAKE;
		else if (r < 71) b.opcode = OP_KILL;
		else if (r < 75) b.opcode = OP_SETPRI;
		else if (r < 82) b.opcode = OP_EXIT;
		else if (r < 90) b.opcode = OP_REAP;
		else if (r < 98) b.opcode = OP_TICK;
		else b.opcode = opcode_t'($urandom_range(11, 15));
		return b;
	endfunction

	// result checker and stall generator
	always @(posedge clk) begin
		out_beat_t e;
		out_beat_t dw;
		logic c;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (sched_results_q.size() == 0) begin
					errors++;
					if (mism < 10) $display("unexpected beat %h", out_data);
					mism++;
				end else begin
					e = sched_results_q.pop_front();
					c = chk_q.size() ? chk_q.pop_front() : 0;
					if (c) begin
						dw = dir_want_q.pop_front();
						if (dw != e) begin
							errors++;
							if (mism < 10)
								$display("table row disagrees: exp %h pred %h", dw, e);
							mism++;
						end
					end
					if (out_data !== e) begin
						errors++;
						if (mism < 10)
							$display("mismatch: exp ok=%b slot=%0d pid=%0d rdy=%0d slp=%0d k=%b act %h",
								e.ok, e.result_slot, e.result_pid, e.ready_count,
								e.sleep_count, e.was_killed, out_data);
						mism++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= p_stall);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_rows [$];
		out_beat_t w;
		errors = 0;
		mism = 0;
		idle_cycles = 0;
		p_send = 0;
		p_stall = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_valid = 0;
		out_ready = 1;
		in_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_state[i] = ST_FREE;
			tbl_pid[i] = 0; tbl_pri[i] = 0; tbl_pass[i] = 0; tbl_chan[i] = 0;
			tbl_kill[i] = 0; tbl_rdy[i] = 0; tbl_slp[i] = 0;
		end
		pid_next = 1;
		cur_slot = 0;
		cur_valid = 0;
		rot_ptr = 0;
		sched_mode = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table failures, then a full life cycle
		w = '0;
		dir_rows.push_back({1'b1, mk(OP_PICK, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b1, mk(OP_YIELD, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b1, mk(OP_REAP, 63, 0, 0, 0), w});
		dir_rows.push_back({1'b1, mk(OP_KILL, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b1, mk(OP_READY, 63, 0, 0, 0), w});
		dir_rows.push_back({1'b1, mk(opcode_t'(4'd15), 63, 16'hFFFF, 255, '1), w});
		w.ok = 1;
		dir_rows.push_back({1'b1, mk(OP_TICK, 0, 0, 0, 0), w});
		w.result_pid = 1;
		dir_rows.push_back({1'b1, mk(OP_ALLOC, 0, 0, 0, 0), w});
		w.result_pid = 0;
		dir_rows.push_back({1'b1, mk(OP_READY, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b1, mk(OP_SETPRI, 0, 1, 255, 0), w});
		w.result_pid = 1;
		dir_rows.push_back({1'b1, mk(OP_PICK, 0, 0, 0, 0), w});
		w = '0;
		w.ok = 1;
		dir_rows.push_back({1'b1, mk(OP_SLEEP, 0, 0, 0, 32'hFFFF_FFFF), w});
		dir_rows.push_back({1'b1, mk(OP_TICK, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b0, mk(OP_WAKE, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b1, mk(OP_WAKE, 0, 0, 0, 32'hFFFF_FFFF), w});
		dir_rows.push_back({1'b0, mk(OP_PICK, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b0, mk(OP_SLEEP, 0, 0, 0, 7), w});
		dir_rows.push_back({1'b0, mk(OP_KILL, 0, 1, 0, 0), w});
		dir_rows.push_back({1'b0, mk(OP_PICK, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b0, mk(OP_EXIT, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b0, mk(OP_REAP, 0, 0, 0, 0), w});
		dir_rows.push_back({1'b0, mk(OP_REAP, 0, 0, 0, 0), w});
		foreach (dir_rows[i]) send_row(dir_rows[i]);

		// random phases across modes and idling profiles
		for (int ph = 0; ph < 8; ph++) begin
			drain_and_set_mode(2'(ph % 4));
			case (ph % 4)
				0: begin p_send = 0; p_stall = 0; end
				1: begin p_send = 71; p_stall = 0; end
				2: begin p_send = 0; p_stall = 71; end
				default: begin p_send = 15; p_stall = 15; end
			endcase
			for (int n = 0; n < 50; n++) send(rand_beat());
		end
		drain_and_set_mode(MODE_PASS);
		p_send = 0;
		p_stall = 0;
		// allocate ENTRIES+1 times: the table fills to its end and at least the last allocation must fail
		for (int n = 0; n < ENTRIES + 1; n++) send(mk(OP_ALLOC, 0, 0, 0, 0));
		for (int n = 0; n < 40; n++) send(rand_beat());
		in_valid <= 0;
		while (sched_results_q.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		if (errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
